// File: hdl/base64_stream_decoder_assert.svh
// assertion macros shared by the decoder modules
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define B64D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define B64D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/b64d_pkg.sv
package b64d_pkg;

    localparam int CHAR_W   = 8;
    localparam int SEXTET_W = 6;
    localparam int ACCUM_W  = 18;
    localparam int WORD_W   = 24;
    localparam int BYTES_N  = 3;

    localparam logic [CHAR_W-1:0] PAD_CODE = 8'h3D;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHR = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

    // one decoded bundle: up to three bytes caused by one item
    typedef struct packed {
        logic                  valid;
        logic [1:0]            cnt;
        logic [BYTES_N-1:0][7:0] bytes;
        logic [1:0]            status;
        logic                  msg_end;
    } b64d_res_t;

    // bit 6 set marks a character outside the alphabet and pad
    function automatic logic [SEXTET_W:0] sextet_of(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] d;
        logic [SEXTET_W:0] r;
        d = 8'd0;
        r = 7'h40;
        if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            d = ch - 8'h41;
            r = {1'b0, d[SEXTET_W-1:0]};
        end
        else if (ch >= 8'h61 && ch <= 8'h7A)
        begin
            d = ch - 8'h61 + 8'd26;
            r = {1'b0, d[SEXTET_W-1:0]};
        end
        else if (ch >= 8'h30 && ch <= 8'h39)
        begin
            d = ch - 8'h30 + 8'd52;
            r = {1'b0, d[SEXTET_W-1:0]};
        end
        else if (ch == 8'h2B)
        begin
            r = 7'd62;
        end
        else if (ch == 8'h2F)
        begin
            r = 7'd63;
        end
        else if (ch == PAD_CODE)
        begin
            r = 7'd0;
        end
        return r;
    endfunction

endpackage

// File: hdl/base64_stream_decoder.sv
// channel  | dir | tdata (low bit up)                    | tlast    | tuser
// s_axis   | in  | char_code[7:0]                        | msg_last | -
// m_axis   | out | data_byte[7:0], status[9:8], zero pad | msg_end  | run_last
//
// one character enters per cycle unless s_axis stalls; its decode is one
// combinational pass between the input register and the bundle register
// a fourth character yields up to three bytes, sent from the bundle register one
// per cycle while m_tready is high; characters that yield nothing keep flowing meanwhile
// sustained rate: one character per cycle (four characters, three bytes)
// rst_n is asynchronous and clears the group, discard flag and all valids
// a stall on m_axis holds the bundle; s_axis stalls only when a result-making
// character waits for the bundle to drain
module base64_stream_decoder
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // data_byte[7:0], status[9:8], zeros[15:10]
    output logic        m_tlast,
    output logic        m_tuser    // run_last
);

    `include "base64_stream_decoder_assert.svh"

    // input register
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    // result bundle and serializer
    b64d_res_t         bund_reg;
    logic [1:0]        idx_reg;

    b64d_res_t         res;
    logic              run_last;
    logic              bund_ready;
    logic              advance;
    logic              out_fire;
    logic [7:0]        out_byte;

    b64d_unit u_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_code (in_char_reg),
        .msg_last  (in_last_reg),
        .res       (res)
    );

    assign run_last   = (idx_reg == bund_reg.cnt - 2'd1);
    assign out_fire   = bund_reg.valid && m_tready;
    // bundle slot is free now or frees on this cycle's last byte
    assign bund_ready = !bund_reg.valid || (m_tready && run_last);
    // items that make no result never wait for the bundle
    assign advance    = in_valid_reg && (!res.valid || bund_ready);
    assign s_tready   = !in_valid_reg || advance;

    always_comb
    begin
        case (idx_reg)
            2'd0:    out_byte = bund_reg.bytes[0];
            2'd1:    out_byte = bund_reg.bytes[1];
            2'd2:    out_byte = bund_reg.bytes[2];
            default: out_byte = 8'd0;
        endcase
    end

    assign m_tvalid = bund_reg.valid;
    assign m_tdata  = {6'd0, bund_reg.status, out_byte};
    assign m_tuser  = run_last;
    assign m_tlast  = run_last && bund_reg.msg_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bund_reg <= '0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            if (advance && res.valid)
            begin
                bund_reg <= res;
                idx_reg  <= 2'd0;
            end
            else if (out_fire)
            begin
                if (run_last)
                begin
                    bund_reg.valid <= 1'b0;
                    idx_reg        <= 2'd0;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    `B64D_ASSERT_NOW(a_idx_in_range, bund_reg.valid,
        idx_reg < bund_reg.cnt && bund_reg.cnt != 2'd0, "byte index past bundle count")
    `B64D_ASSERT_NOW(a_error_shape, bund_reg.valid && bund_reg.status != STATUS_OK,
        bund_reg.cnt == 2'd1 && bund_reg.msg_end && out_byte == 8'd0,
        "error result not a single final zero byte")
    `B64D_ASSERT_NEXT(a_idx_step, out_fire && !run_last,
        bund_reg.valid && idx_reg == $past(idx_reg) + 2'd1, "serializer skipped a byte")

endmodule

// File: hdl/b64d_unit.sv
module b64d_unit
    import b64d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              msg_last,
    output b64d_res_t         res
);

    `include "base64_stream_decoder_assert.svh"

    logic [ACCUM_W-1:0] accum_reg, accum_next;
    logic [1:0]         pos_reg, pos_next;
    logic               third_pad_reg, third_pad_next;
    logic               discard_reg, discard_next;

    logic [SEXTET_W:0]  sx;
    logic [WORD_W-1:0]  word;
    logic               is_pad;

    assign sx     = sextet_of(char_code);
    assign is_pad = (char_code == PAD_CODE);
    assign word   = {accum_reg, sx[SEXTET_W-1:0]};

    always_comb
    begin
        accum_next     = accum_reg;
        pos_next       = pos_reg;
        third_pad_next = third_pad_reg;
        discard_next   = discard_reg;
        res            = '0;
        if (discard_reg)
        begin
            if (msg_last)
                discard_next = 1'b0;
        end
        else if (msg_last && pos_reg != 2'd3)
        begin
            // message ended mid group
            accum_next     = '0;
            pos_next       = 2'd0;
            third_pad_next = 1'b0;
            res.valid      = 1'b1;
            res.cnt        = 2'd1;
            res.status     = STATUS_BAD_LEN;
            res.msg_end    = 1'b1;
        end
        else if (sx[SEXTET_W])
        begin
            accum_next     = '0;
            pos_next       = 2'd0;
            third_pad_next = 1'b0;
            discard_next   = !msg_last;
            res.valid      = 1'b1;
            res.cnt        = 2'd1;
            res.status     = STATUS_BAD_CHR;
            res.msg_end    = 1'b1;
        end
        else if (pos_reg != 2'd3)
        begin
            if (pos_reg == 2'd2)
                third_pad_next = is_pad;
            accum_next = {accum_reg[ACCUM_W-SEXTET_W-1:0], sx[SEXTET_W-1:0]};
            pos_next   = pos_reg + 2'd1;
        end
        else
        begin
            accum_next     = '0;
            pos_next       = 2'd0;
            third_pad_next = 1'b0;
            res.valid      = 1'b1;
            res.cnt        = 2'd3;
            // trailing pad on the final group drops bytes
            if (msg_last && is_pad)
                res.cnt = third_pad_reg ? 2'd1 : 2'd2;
            res.bytes[0]   = word[23:16];
            res.bytes[1]   = word[15:8];
            res.bytes[2]   = word[7:0];
            res.status     = STATUS_OK;
            res.msg_end    = msg_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg     <= '0;
            pos_reg       <= 2'd0;
            third_pad_reg <= 1'b0;
            discard_reg   <= 1'b0;
        end
        else if (step)
        begin
            accum_reg     <= accum_next;
            pos_reg       <= pos_next;
            third_pad_reg <= third_pad_next;
            discard_reg   <= discard_next;
        end
    end

    `B64D_ASSERT_NOW(a_discard_clean, discard_reg,
        pos_reg == 2'd0 && accum_reg == '0, "group not cleared while discarding")
    `B64D_ASSERT_NOW(a_ok_on_fourth, res.valid && res.status == STATUS_OK,
        pos_reg == 2'd3 && !discard_reg, "bytes emitted outside the fourth character")
    `B64D_ASSERT_NEXT(a_group_restart, step && res.valid,
        pos_reg == 2'd0, "group not restarted after a result")

endmodule

// File: test/base64_stream_decoder_tb.sv
module base64_stream_decoder_tb;
    import b64d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS     = 110;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT   = 1000;

    // one decoded item as seen on m_axis
    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] status;
        logic       run_last;
        logic       msg_end;
    } byte_result_t;

    // tracks the decoder state and the bytes it still owes
    class decode_scoreboard;
        byte_result_t owed_q[$];
        logic [17:0]  accum;
        logic [1:0]   pos;
        logic         third_pad;
        logic         skipping;
        int           failures;

        function new();
            owed_q.delete();
            accum     = '0;
            pos       = '0;
            third_pad = 1'b0;
            skipping  = 1'b0;
            failures  = 0;
        endfunction

        // -1 for anything outside the alphabet and pad
        static function int sextet_value(input logic [7:0] ch);
            if (ch >= "A" && ch <= "Z") return ch - "A";
            if (ch >= "a" && ch <= "z") return ch - "a" + 26;
            if (ch >= "0" && ch <= "9") return ch - "0" + 52;
            if (ch == "+") return 62;
            if (ch == "/") return 63;
            if (ch == PAD_CODE) return 0;
            return -1;
        endfunction

        function void clear_group();
            accum     = '0;
            pos       = '0;
            third_pad = 1'b0;
        endfunction

        function void owe(input logic [7:0] b, input logic [1:0] st, input logic rl,
                          input logic me);
            byte_result_t r;
            r.data_byte = b;
            r.status    = st;
            r.run_last  = rl;
            r.msg_end   = me;
            owed_q.push_back(r);
        endfunction

        // returns 1 when the character is swallowed by a discarded message
        function bit note_char(input logic [7:0] ch, input logic last);
            int          sx;
            int          n;
            logic [23:0] word;
            if (skipping)
            begin
                if (last) skipping = 1'b0;
                return 1'b1;
            end
            // short message wins over a bad character
            if (last && pos != 2'd3)
            begin
                clear_group();
                owe(8'h00, STATUS_BAD_LEN, 1'b1, 1'b1);
                return 1'b0;
            end
            sx = sextet_value(ch);
            if (sx < 0)
            begin
                clear_group();
                skipping = !last;
                owe(8'h00, STATUS_BAD_CHR, 1'b1, 1'b1);
                return 1'b0;
            end
            if (pos != 2'd3)
            begin
                if (pos == 2'd2) third_pad = (ch == PAD_CODE);
                accum = {accum[11:0], 6'(sx)};
                pos   = pos + 2'd1;
                return 1'b0;
            end
            word = {accum, 6'(sx)};
            n    = 3;
            // padding only trims bytes on the closing group
            if (last && ch == PAD_CODE) n = third_pad ? 1 : 2;
            for (int i = 0; i < n; i++)
                owe(word[23-8*i -: 8], STATUS_OK, i == n - 1, (i == n - 1) && last);
            clear_group();
            return 1'b0;
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got)
            begin
                failures++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want,
                         got);
            end
        endfunction

        function void check_result(input byte_result_t got);
            byte_result_t want;
            if (owed_q.size() == 0)
            begin
                failures++;
                $display("%0t ns: unexpected item, expected none, actual byte %h status %0d",
                         $time, got.data_byte, got.status);
                return;
            end
            want = owed_q.pop_front();
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("status", want.status, got.status);
            compare_field("run_last", want.run_last, got.run_last);
            compare_field("msg_end", want.msg_end, got.msg_end);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    decode_scoreboard sb = new();

    int live_items    = 0;
    int idle_cycles   = 0;
    bit src_calm      = 1'b0;
    bit sink_calm     = 1'b0;
    bit long_hold_req = 1'b0;
    bit holding       = 1'b0;

    base64_stream_decoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] alpha_char(input int idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        return (idx == 62) ? "+" : "/";
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(0, 255));
        while (decode_scoreboard::sextet_value(ch) >= 0);
        return ch;
    endfunction

    // offer one character and hold it until the decoder takes it
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_text(input string text, input bit last_at_end);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i], last_at_end && (i == text.len() - 1));
    endtask

    // stop offering until every owed byte has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic send_random_message();
        logic [7:0] text[$];
        int         groups;
        int         fault;
        int         top;
        groups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
        for (int i = 0; i < groups * 4; i++)
            text.push_back(($urandom_range(0, 19) == 0) ? PAD_CODE
                                                        : alpha_char($urandom_range(0, 63)));
        top = text.size() - 1;
        case ($urandom_range(0, 3))
            1: text[top] = PAD_CODE;
            2:
            begin
                text[top]     = PAD_CODE;
                text[top - 1] = PAD_CODE;
            end
            3:
            begin
                // third pad with a real closing character keeps all three bytes
                text[top - 1] = PAD_CODE;
                text[top]     = alpha_char($urandom_range(0, 63));
            end
            default: ;
        endcase
        fault = $urandom_range(0, 9);
        if (fault == 0)
        begin
            text[$urandom_range(0, top)] = bad_char();
        end
        else if (fault == 1)
        begin
            // trim the tail so the message ends mid group
            repeat ($urandom_range(1, 3)) text.delete(text.size() - 1);
        end
        else if (fault == 2)
        begin
            // raw noise across the whole byte range
            text.delete();
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
        end
        src_calm = ($urandom_range(0, 4) == 0);
        foreach (text[i]) send_char(text[i], i == text.size() - 1);
    endtask

    // monitor: both handshakes sampled at the edge where they complete
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (!sb.note_char(s_tdata, s_tlast)) live_items++;
            end
            if (m_tvalid && m_tready)
                sb.check_result('{data_byte: m_tdata[7:0], status: m_tdata[9:8],
                                  run_last: m_tuser, msg_end: m_tlast});
        end
    end

    // watchdog on cycles with no traffic on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL base64_stream_decoder");
            $finish;
        end
    end

    // receiver: random stalls, calm stretches and one long hold-off on request
    initial
    begin
        int stall;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                holding       = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                holding = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
                stall = pick_gap(sink_calm);
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int start_count;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // padding forms on the closing group
        send_text("TWE=", 1'b1);
        send_text("TQ==", 1'b1);
        send_text("QQ=B", 1'b1);
        // pad in mid stream decodes as zero, then a full closing group
        send_text("/=+9", 1'b0);
        send_text("z=09", 1'b1);
        // bad character mid message, rest discarded
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
        // short message beats a bad character
        send_char(8'h80, 1'b1);
        // bad character as the closing character
        send_text("abc", 1'b0);
        send_char(8'h7F, 1'b1);

        wait_drained();

        // long receiver hold-off while a long message keeps coming
        long_hold_req = 1'b1;
        while (!holding) @(posedge clk);
        src_calm = 1'b1;
        for (int i = 0; i < 32; i++)
            send_char(alpha_char($urandom_range(0, 63)), i == 31);

        start_count = live_items;
        while (live_items - start_count < RANDOM_ITEMS)
        begin
            send_random_message();
            if ($urandom_range(0, 19) == 0) wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
        begin
            $display("PASS base64_stream_decoder");
        end
        else
        begin
            $display("FAIL base64_stream_decoder");
        end
        $finish;
    end

endmodule
